// ----- hdl/urta_pkg.sv -----
// Shared types, constants and the digit-to-ASCII function of the radix-to-ASCII converter.
package urta_pkg;

   localparam int STEP_BITS  = 8;
   localparam int DIGIT_BITS = 4;
   localparam int RADIX_BITS = 5;
   localparam int CHAR_BITS  = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;
   localparam logic [DIGIT_BITS-1:0] DECIMAL_DIGITS = 4'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = 8'h66;

   typedef struct packed {
      logic start;
      logic div_step;
      logic rd_issue;
      logic emit;
   } urta_cmd_type;

   typedef struct packed {
      logic bad_radix;
      logic digit_done;
      logic more_digits;
      logic out_free;
      logic last_digit;
   } urta_sts_type;

   function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] digit,
                                                         input logic upper);
      logic [CHAR_BITS-1:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (digit < DECIMAL_DIGITS) begin
         return CHAR_ZERO + CHAR_BITS'(digit);
      end
      return letter_base + CHAR_BITS'(digit - DECIMAL_DIGITS);
   endfunction

endpackage

// ----- hdl/urta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module urta_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/urta_ctrl.sv -----
// Controller state machine: accept, divide, read back and emit digits.
module urta_ctrl import urta_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  urta_sts_type sts,
   output urta_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_READ = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || (sts.bad_radix && !sts.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               if (!sts.bad_radix) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.digit_done && !sts.more_digits) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.last_digit ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/urta_dpath.sv -----
// Datapath: shared restoring divider, digit store, read-back index and output register.
module urta_dpath import urta_pkg::*; #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           req_value,
   input  logic [RADIX_BITS-1:0] req_radix,
   input  logic                  req_upper_case,
   input  urta_cmd_type          cmd,
   output urta_sts_type          sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last,
   output logic                  rsp_bad_radix
);

   localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int QW    = STEPS * STEP_BITS;
   localparam int DEPTH = VALUE_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [QW-1:0]          quot_ff, quot_in;
   logic [DIGIT_BITS-1:0]  rem_ff, rem_in;
   logic                   nz_ff, nz_in;
   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic                   upper_ff, upper_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   bad_ff, bad_in;

   logic [STEP_BITS-1:0]   div_top;
   logic [STEP_BITS-1:0]   div_qbits;
   logic [DIGIT_BITS-1:0]  div_rem;
   logic                   wr_en;
   logic [DIGIT_BITS-1:0]  ram_rdata;
   logic                   load_out;
   logic                   req_bad;

   assign div_top = quot_ff[QW-1 -: STEP_BITS];

   always_comb begin
      logic [DIGIT_BITS:0] part;
      part      = '0;
      div_rem   = rem_ff;
      div_qbits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         part = {div_rem, div_top[i]};
         if (part >= radix_ff) begin
            div_qbits[i] = 1'b1;
            part         = part - radix_ff;
         end
         div_rem = part[DIGIT_BITS-1:0];
      end
   end

   assign req_bad = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);

   always_comb begin
      sts.bad_radix   = req_bad;
      sts.digit_done  = (step_ff == SW'(STEPS - 1));
      sts.more_digits = (nz_ff || (|div_qbits)) && (count_ff != CW'(DEPTH - 1));
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
      sts.last_digit  = (rd_idx_ff == '0);
   end

   assign wr_en    = cmd.div_step && sts.digit_done;
   assign load_out = cmd.emit || (cmd.start && req_bad);

   always_comb begin
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      nz_in     = nz_ff;
      radix_in  = radix_ff;
      upper_in  = upper_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.start && !req_bad) begin
         quot_in  = QW'(req_value[VALUE_WIDTH-1:0]);
         rem_in   = '0;
         nz_in    = 1'b0;
         radix_in = req_radix;
         upper_in = req_upper_case;
         step_in  = '0;
         count_in = '0;
      end
      if (cmd.div_step) begin
         quot_in = (quot_ff << STEP_BITS) | QW'(div_qbits);
         rem_in  = div_rem;
         nz_in   = nz_ff || (|div_qbits);
         step_in = step_ff + 1'b1;
         if (sts.digit_done) begin
            rem_in    = '0;
            nz_in     = 1'b0;
            step_in   = '0;
            count_in  = count_ff + 1'b1;
            rd_idx_in = count_ff[AW-1:0];
         end
      end
      if (cmd.emit) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_comb begin
      char_in      = char_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (cmd.emit) begin
            char_in = digit_ascii(ram_rdata, upper_ff);
            last_in = sts.last_digit;
            bad_in  = 1'b0;
         end else begin
            char_in = CHAR_NUL;
            last_in = 1'b1;
            bad_in  = 1'b1;
         end
      end
   end

   urta_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (div_rem),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quot_ff      <= quot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      nz_ff     <= nz_in;
      radix_ff  <= radix_in;
      upper_ff  <= upper_in;
      step_ff   <= step_in;
      rd_idx_ff <= rd_idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;
   assign rsp_bad_radix  = bad_ff;

   a_bad_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bad_ff |-> last_ff && (char_ff == CHAR_NUL))
      else $error("bad radix response without last or with a nonzero character");

   a_good_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !bad_ff |->
         ((char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE)) ||
         ((char_ff >= CHAR_UPPER_A) && (char_ff <= CHAR_UPPER_F)) ||
         ((char_ff >= CHAR_LOWER_A) && (char_ff <= CHAR_LOWER_F)))
      else $error("response character is not a digit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("digit count exceeds the digit store depth");

   a_read_written: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (CW'(rd_idx_ff) < count_ff))
      else $error("digit store read beyond the digits of this request");

endmodule

// ----- hdl/unsigned_radix_to_ascii.sv -----
// Top level of the unsigned radix-to-ASCII converter.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_value, req_radix, req_upper_case
//   rsp_      out         rsp_valid / rsp_stall  rsp_digit_char, rsp_last, rsp_bad_radix
//
// A good request is divided into D digits, one 8-bit restoring divide step per cycle,
// then each digit passes through the registered read of the digit RAM and enters the
// output register once that register is free.
// A bad radix goes straight to the output register.
// Reset is synchronous; the digit RAM needs no clearing pass.
// rsp_stall holds the output register; the next request is taken once the final
// digit sits in it, and a bad-radix request waits for the output register to free.
module unsigned_radix_to_ascii import urta_pkg::*; #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [63:0]           req_value,
   input  logic [RADIX_BITS-1:0] req_radix,
   input  logic                  req_upper_case,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last,
   output logic                  rsp_bad_radix
);

   urta_cmd_type cmd;
   urta_sts_type sts;

   urta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   urta_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .req_upper_case (req_upper_case),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_radix  (rsp_bad_radix)
   );

endmodule
